FILE: rtl/rras_pkg.sv
// ----------------------------------------------------------------------------
// rras_pkg
// Shared types, constants and helpers for the round-robin aging scheduler.
// ----------------------------------------------------------------------------
package rras_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CFG_W   = 16;
    localparam int QUANT_W = 16;
    localparam int WAIT_W  = 8;
    localparam int FIELD_W = 4;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    // register indexes on the config port
    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_AGING   = 1'b1;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SS_IDLE  = 2'd0,
        SS_READY = 2'd1,
        SS_RUN   = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DECIDE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic load_item;
        logic apply_set;
        logic tick_update;
        logic scan_step;
        logic finish;
    } rras_cmd_t;

    typedef struct packed {
        logic is_set;
        logic expire;
        logic scan_last;
        logic out_free;
    } rras_status_t;

    // low bits of a slot index as carried on the result ports
    function automatic logic [FIELD_W-1:0] slot_to_field(input slot_idx_t idx);
        logic [SLOT_W+FIELD_W-1:0] ext;
        begin
            ext = {{FIELD_W{1'b0}}, idx};
            return ext[FIELD_W-1:0];
        end
    endfunction

    // slot port value to table index (only used when in range)
    function automatic slot_idx_t field_to_slot(input logic [FIELD_W-1:0] f);
        logic [SLOT_W+FIELD_W-1:0] ext;
        begin
            ext = {{SLOT_W{1'b0}}, f};
            return ext[SLOT_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/rras_ctrl.sv
// ----------------------------------------------------------------------------
// rras_ctrl
// Sequencer: accepts a word, decides, walks the slot table, reports.
// ----------------------------------------------------------------------------
module rras_ctrl
    import rras_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  rras_status_t status,
    output rras_cmd_t    cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            FSM_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = FSM_DECIDE;
                end
            end
            FSM_DECIDE:
            begin
                if (status.is_set)
                begin
                    if (status.out_free)
                    begin
                        cmd.apply_set = 1'b1;
                        state_next    = FSM_IDLE;
                    end
                end
                else if (status.expire)
                begin
                    // count clears and the walk starts at slot zero
                    cmd.tick_update = 1'b1;
                    state_next      = FSM_SCAN;
                end
                else if (status.out_free)
                begin
                    cmd.tick_update = 1'b1;
                    state_next      = FSM_IDLE;
                end
            end
            FSM_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rras_dp.sv
// ----------------------------------------------------------------------------
// rras_dp
// Datapath: config, slot table, quantum counter, scan trackers, result word.
// ----------------------------------------------------------------------------
module rras_dp
    import rras_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               operation,
    input  logic [FIELD_W-1:0] slot,
    input  logic [1:0]         new_state,
    input  rras_cmd_t          cmd,
    output rras_status_t       status,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               switched,
    output logic [FIELD_W-1:0] from_slot,
    output logic [FIELD_W-1:0] to_slot,
    output logic               by_aging
);

    localparam slot_idx_t LAST_IDX = slot_idx_t'(SLOTS - 1);

    // config
    logic [QUANT_W-1:0] quantum_reg;
    logic [WAIT_W-1:0]  thresh_reg;

    // table and scheduler state
    slot_state_t        slot_state_reg [SLOTS];
    slot_state_t        slot_state_next[SLOTS];
    logic [WAIT_W-1:0]  wait_count_reg [SLOTS];
    logic [WAIT_W-1:0]  wait_count_next[SLOTS];
    logic [QUANT_W-1:0] tick_count_reg, tick_count_next;
    slot_idx_t          current_reg, current_next;

    // captured word
    logic               op_reg, op_next;
    logic [FIELD_W-1:0] slot_reg, slot_next;
    logic [1:0]         nstate_reg, nstate_next;

    // scan trackers
    slot_idx_t scan_idx_reg, scan_idx_next;
    logic      age_found_reg, age_found_next;
    slot_idx_t age_pick_reg, age_pick_next;
    logic      hi_found_reg, hi_found_next;
    slot_idx_t hi_pick_reg, hi_pick_next;
    logic      lo_found_reg, lo_found_next;
    slot_idx_t lo_pick_reg, lo_pick_next;
    logic      cur_run_reg, cur_run_next;

    // result word
    logic               out_valid_reg, out_valid_next;
    logic               switched_reg, switched_next;
    logic [FIELD_W-1:0] from_reg, from_next;
    logic [FIELD_W-1:0] to_reg, to_next;
    logic               aged_reg, aged_next;

    // combinational helpers
    slot_state_t        scan_st;
    logic [WAIT_W-1:0]  scan_w;
    logic [WAIT_W-1:0]  w_inc;
    logic               scan_ready;
    logic               age_hit;
    logic [QUANT_W:0]   tick_sum;
    logic [QUANT_W-1:0] limit;
    logic               expire;
    logic               out_free;
    logic               set_ok;
    slot_idx_t          set_idx;
    logic               push;
    logic               found;
    slot_idx_t          pick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANT_W'(10);
            thresh_reg  <= WAIT_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUANTUM: quantum_reg <= cfg_data[QUANT_W-1:0];
                CFG_AGING:   thresh_reg  <= cfg_data[WAIT_W-1:0];
                default:     quantum_reg <= quantum_reg;
            endcase
        end
    end

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;

        scan_st    = slot_state_reg[scan_idx_reg];
        scan_w     = wait_count_reg[scan_idx_reg];
        w_inc      = (scan_w == {WAIT_W{1'b1}}) ? scan_w : scan_w + WAIT_W'(1);
        scan_ready = (scan_st == SS_READY);
        age_hit    = scan_ready && (w_inc > thresh_reg) && !age_found_reg;

        // zero quantum acts as one
        limit    = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
        tick_sum = {1'b0, tick_count_reg} + (QUANT_W+1)'(1);
        expire   = tick_sum >= {1'b0, limit};

        set_ok  = ({{SLOT_W{1'b0}}, slot_reg} < (SLOT_W+FIELD_W)'(SLOTS))
                  && (nstate_reg inside {SS_IDLE, SS_READY, SS_RUN});
        set_idx = field_to_slot(slot_reg);

        found = age_found_reg || hi_found_reg || lo_found_reg;
        pick  = age_found_reg ? age_pick_reg : (hi_found_reg ? hi_pick_reg : lo_pick_reg);

        slot_state_next = slot_state_reg;
        wait_count_next = wait_count_reg;
        tick_count_next = tick_count_reg;
        current_next    = current_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        nstate_next     = nstate_reg;
        scan_idx_next   = scan_idx_reg;
        age_found_next  = age_found_reg;
        age_pick_next   = age_pick_reg;
        hi_found_next   = hi_found_reg;
        hi_pick_next    = hi_pick_reg;
        lo_found_next   = lo_found_reg;
        lo_pick_next    = lo_pick_reg;
        cur_run_next    = cur_run_reg;
        switched_next   = switched_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        aged_next       = aged_reg;
        push            = 1'b0;

        if (cmd.load_item)
        begin
            op_next     = operation;
            slot_next   = slot;
            nstate_next = new_state;
        end

        if (cmd.apply_set)
        begin
            if (set_ok)
            begin
                slot_state_next[set_idx] = slot_state_t'(nstate_reg);
                if (slot_state_t'(nstate_reg) == SS_RUN)
                begin
                    current_next = set_idx;
                end
            end
            push          = 1'b1;
            switched_next = 1'b0;
            from_next     = '0;
            to_next       = '0;
            aged_next     = 1'b0;
        end

        if (cmd.tick_update)
        begin
            if (expire)
            begin
                tick_count_next = '0;
                scan_idx_next   = '0;
                age_found_next  = 1'b0;
                hi_found_next   = 1'b0;
                lo_found_next   = 1'b0;
                cur_run_next    = 1'b0;
            end
            else
            begin
                tick_count_next = tick_sum[QUANT_W-1:0];
                push            = 1'b1;
                switched_next   = 1'b0;
                from_next       = '0;
                to_next         = '0;
                aged_next       = 1'b0;
            end
        end

        if (cmd.scan_step)
        begin
            // age, and clear the first slot past the threshold right away
            if (scan_ready)
            begin
                wait_count_next[scan_idx_reg] = age_hit ? '0 : w_inc;
                if (age_hit)
                begin
                    age_found_next = 1'b1;
                    age_pick_next  = scan_idx_reg;
                end
                if (!hi_found_reg && (scan_idx_reg > current_reg))
                begin
                    hi_found_next = 1'b1;
                    hi_pick_next  = scan_idx_reg;
                end
                if (!lo_found_reg)
                begin
                    lo_found_next = 1'b1;
                    lo_pick_next  = scan_idx_reg;
                end
            end
            if (scan_idx_reg == current_reg)
            begin
                cur_run_next = (scan_st == SS_RUN);
            end
            scan_idx_next = scan_idx_reg + slot_idx_t'(1);
        end

        if (cmd.finish)
        begin
            push = 1'b1;
            if (found)
            begin
                if (cur_run_reg)
                begin
                    slot_state_next[current_reg] = SS_READY;
                end
                slot_state_next[pick] = SS_RUN;
                current_next          = pick;
                switched_next         = 1'b1;
                from_next             = slot_to_field(current_reg);
                to_next               = slot_to_field(pick);
                aged_next             = age_found_reg;
            end
            else
            begin
                switched_next = 1'b0;
                from_next     = '0;
                to_next       = '0;
                aged_next     = 1'b0;
            end
        end

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_state_reg[i] <= SS_IDLE;
                wait_count_reg[i] <= '0;
            end
            tick_count_reg <= '0;
            current_reg    <= '0;
            scan_idx_reg   <= '0;
            age_found_reg  <= 1'b0;
            hi_found_reg   <= 1'b0;
            lo_found_reg   <= 1'b0;
            cur_run_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_state_reg <= slot_state_next;
            wait_count_reg <= wait_count_next;
            tick_count_reg <= tick_count_next;
            current_reg    <= current_next;
            scan_idx_reg   <= scan_idx_next;
            age_found_reg  <= age_found_next;
            hi_found_reg   <= hi_found_next;
            lo_found_reg   <= lo_found_next;
            cur_run_reg    <= cur_run_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        nstate_reg   <= nstate_next;
        age_pick_reg <= age_pick_next;
        hi_pick_reg  <= hi_pick_next;
        lo_pick_reg  <= lo_pick_next;
        switched_reg <= switched_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        aged_reg     <= aged_next;
    end

    assign status.is_set    = (op_t'(op_reg) == OP_SET);
    assign status.expire    = expire;
    assign status.scan_last = (scan_idx_reg == LAST_IDX);
    assign status.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign switched  = switched_reg;
    assign from_slot = from_reg;
    assign to_slot   = to_reg;
    assign by_aging  = aged_reg;

endmodule

FILE: rtl/round_robin_aging_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_aging_scheduler
// Quantum-timed round-robin scheduler with aging over a fixed slot table.
// ----------------------------------------------------------------------------
// One word in, one result word out. A slot write or a tick that does not end
// the quantum is decided from the captured word, and its result goes into the
// output register as soon as that register is free. A tick that ends the
// quantum walks the slot table one slot per cycle (aging each ready slot and
// tracking the aging and round-robin candidates), then makes the switch in
// the finish state and writes its result. The input is taken only while the
// sequencer is idle, the cycle after the result is written, so the block
// works on one word at a time. A finished result sits in the output register
// and the next word may be taken and worked on while it waits; the sequencer
// holds before writing its own result until the output register is free.
module round_robin_aging_scheduler
    import rras_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [FIELD_W-1:0] slot,
    input  logic [1:0]         new_state,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               switched,
    output logic [FIELD_W-1:0] from_slot,
    output logic [FIELD_W-1:0] to_slot,
    output logic               by_aging
);

    rras_cmd_t    cmd;
    rras_status_t status;

    rras_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rras_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .slot      (slot),
        .new_state (new_state),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .switched  (switched),
        .from_slot (from_slot),
        .to_slot   (to_slot),
        .by_aging  (by_aging)
    );

endmodule

FILE: rtl/rras_chk.sv
// ----------------------------------------------------------------------------
// rras_chk
// Port-level checks for the round-robin aging scheduler.
// ----------------------------------------------------------------------------
module rras_chk
    import rras_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               switched,
    input logic [FIELD_W-1:0] from_slot,
    input logic [FIELD_W-1:0] to_slot,
    input logic               by_aging
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(switched)
            && $stable(from_slot) && $stable(to_slot) && $stable(by_aging))
        else $error("result word changed while stalled");

    // one word at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous word in flight");

    // no switch reports all-zero fields
    a_no_switch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !switched |-> from_slot == '0 && to_slot == '0 && !by_aging)
        else $error("fields set without a switch");

    // a slot write never switches, so its result cannot show aging
    a_aging_needs_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && by_aging |-> switched)
        else $error("aging flag without switch");

endmodule

bind round_robin_aging_scheduler rras_chk u_rras_chk (.*);
